/* sv/block_bitmap_allocator_core_defines.svh */
// Assertion macros for the block bitmap allocator checker.
`ifndef BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bba_pkg.sv */
// Types and constants of the block bitmap allocator.
`default_nettype none

package bba_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 256;
   localparam int ADDR_LIMIT         = 256;   // block numbers are 8 bits
   localparam int MAP_CAP_BYTES      = ADDR_LIMIT / 8;
   localparam int BLOCK_W            = 8;
   localparam int COUNT_W            = 9;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 9'd256;
   localparam logic               REG_BLOCK_COUNT   = 1'b0;   // register index bit

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLAIM = 2'd2,
      CMD_TEST  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type              command;
      logic [BLOCK_W-1:0]   block_number;
   } req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]   result_block;
      status_type           status;
      logic                 was_used;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic step;
      logic commit;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_hit;
      logic scan_end;
   } dp_stat_type;

endpackage

`default_nettype wire

/* sv/bba_dp.sv */
// Datapath: request registers, used-bit map, byte scanner and result register.
`default_nettype none

module bba_dp #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bba_pkg::req_type             req_payload,
   input  wire logic [bba_pkg::COUNT_W-1:0]  block_count,
   input  wire bba_pkg::dp_cmd_type          cmd,
   output bba_pkg::dp_stat_type              stat,
   output bba_pkg::rsp_type                  rsp_payload
);

   localparam int MapBytes = (MAX_BLOCKS + 7) / 8;
   localparam int MapDepth = (MapBytes < bba_pkg::MAP_CAP_BYTES) ? MapBytes
                                                                  : bba_pkg::MAP_CAP_BYTES;
   localparam int IdxW     = (MapDepth > 1) ? $clog2(MapDepth) : 1;
   localparam int CntW     = $clog2(MapDepth + 1);
   localparam int Limit    = (MAX_BLOCKS < bba_pkg::ADDR_LIMIT) ? MAX_BLOCKS
                                                                : bba_pkg::ADDR_LIMIT;
   localparam logic [bba_pkg::COUNT_W-1:0] LimitCount = bba_pkg::COUNT_W'(Limit);

   bba_pkg::cmd_type                 cmd_ff;
   logic [bba_pkg::BLOCK_W-1:0]      blk_ff;
   logic [CntW-1:0]                  scan_idx_ff;
   logic [7:0]                       map_ff [MapDepth];
   bba_pkg::rsp_type                 rsp_ff;
   bba_pkg::rsp_type                 rsp_in;

   logic [bba_pkg::COUNT_W-1:0]      eff_count;
   logic [bba_pkg::COUNT_W-1:0]      scan_base;
   logic [bba_pkg::COUNT_W-1:0]      remain;
   logic                             scan_end;
   logic [7:0]                       scan_byte;
   logic [7:0]                       valid_mask;
   logic [7:0]                       free_bits;
   logic [2:0]                       hit_pos;
   logic                             scan_hit;
   logic [IdxW-1:0]                  single_idx;
   logic [7:0]                       single_byte;
   logic [7:0]                       bit_mask;
   logic                             in_range;
   logic                             wr_en;
   logic [IdxW-1:0]                  wr_idx;
   logic [7:0]                       wr_data;

   assign eff_count = (block_count > LimitCount) ? LimitCount : block_count;

   // scanner: one map byte per cycle
   assign scan_base = bba_pkg::COUNT_W'(scan_idx_ff) << 3;
   assign scan_end  = (scan_base >= eff_count);
   assign remain    = eff_count - scan_base;
   assign scan_byte = map_ff[scan_idx_ff[IdxW-1:0]];

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         valid_mask[b] = (bba_pkg::COUNT_W'(b) < remain);
      end
   end

   assign free_bits = ~scan_byte & valid_mask;
   assign scan_hit  = !scan_end && (free_bits != 8'd0);

   always_comb begin
      hit_pos = 3'd0;
      for (int b = 7; b >= 0; b--) begin
         if (free_bits[b]) begin
            hit_pos = 3'(b);
         end
      end
   end

   // single-block access
   assign single_idx  = blk_ff[IdxW+2:3];
   assign single_byte = map_ff[single_idx];
   assign bit_mask    = 8'd1 << blk_ff[2:0];
   assign in_range    = ({1'b0, blk_ff} < eff_count);

   always_comb begin
      rsp_in.result_block = blk_ff;
      rsp_in.status       = bba_pkg::STATUS_OK;
      rsp_in.was_used     = 1'b0;
      wr_en               = 1'b0;
      wr_idx              = single_idx;
      wr_data             = single_byte;
      if (cmd_ff == bba_pkg::CMD_ALLOC) begin
         wr_idx  = scan_idx_ff[IdxW-1:0];
         wr_data = scan_byte | (8'd1 << hit_pos);
         if (scan_hit) begin
            rsp_in.result_block = {scan_base[7:3], hit_pos};
            wr_en               = 1'b1;
         end else begin
            rsp_in.result_block = '0;
            rsp_in.status       = bba_pkg::STATUS_FULL;
         end
      end else if (!in_range) begin
         rsp_in.status = bba_pkg::STATUS_RANGE;
      end else begin
         rsp_in.was_used = |(single_byte & bit_mask);
         case (cmd_ff)
            bba_pkg::CMD_FREE: begin
               wr_en   = 1'b1;
               wr_data = single_byte & ~bit_mask;
            end
            bba_pkg::CMD_CLAIM: begin
               wr_en   = 1'b1;
               wr_data = single_byte | bit_mask;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff      <= req_payload.command;
         blk_ff      <= req_payload.block_number;
         scan_idx_ff <= '0;
      end else if (cmd.step) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MapDepth; i++) begin
            map_ff[i] <= 8'd0;
         end
      end else if (cmd.commit && wr_en) begin
         map_ff[wr_idx] <= wr_data;
      end
   end

   assign stat.scan_hit = scan_hit;
   assign stat.scan_end = scan_end;
   assign rsp_payload   = rsp_ff;

endmodule

`default_nettype wire

/* sv/bba_ctrl.sv */
// Controller: request/response handshake and command sequencing.
`default_nettype none

module bba_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire bba_pkg::cmd_type      req_command,
   input  wire logic                  rsp_ready,
   input  wire bba_pkg::dp_stat_type  stat,
   output logic                       req_ready,
   output logic                       rsp_valid,
   output bba_pkg::dp_cmd_type        cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SINGLE,
      S_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result register can be loaded when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready_in = 1'b1;
            if (req_valid && req_ready_ff) begin
               cmd.capture  = 1'b1;
               req_ready_in = 1'b0;
               state_in     = (req_command == bba_pkg::CMD_ALLOC) ? S_SCAN : S_SINGLE;
            end
         end
         S_SINGLE: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               req_ready_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.scan_hit || stat.scan_end) begin
               if (out_free) begin
                  cmd.commit   = 1'b1;
                  req_ready_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* sv/block_bitmap_allocator_core.sv */
// Block bitmap allocator: one used bit per block, first-fit allocate, free, claim, test.
//
// Keeps a used-bit map of up to 256 blocks, all free after reset. Each request
// carries a command: allocate grants the lowest free block below the effective
// count (min of block_count, MAX_BLOCKS and 256) and marks it used, or reports
// a full store; free clears a block's bit, claim sets it, test only reads it.
// A block number at or above the effective count returns out-of-range status
// and leaves the map alone. Free, claim and test commit their result from the
// state after acceptance, once the result register is free. Allocate scans the
// map one byte per cycle from byte 0 until it finds a free bit or passes the
// effective count, which reports a full store. One request is in work at a
// time; the response sits in an output register, so a new request is taken
// while the previous response waits for rsp_ready. The whole map clears on
// reset. block_count sits at byte address 0 of the APB-style port and resets
// to 256; write it only while the block is idle.
`default_nettype none

module block_bitmap_allocator_core #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire bba_pkg::req_type                 req_payload,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output bba_pkg::rsp_type                      rsp_payload,
   // register port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [bba_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [bba_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);

   logic [bba_pkg::COUNT_W-1:0] block_count_ff;
   logic [bba_pkg::COUNT_W-1:0] block_count_in;
   logic                        csr_wr;
   bba_pkg::dp_cmd_type         dp_cmd;
   bba_pkg::dp_stat_type        dp_stat;

   // register port: never inserts wait states, write in the access phase
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == bba_pkg::REG_BLOCK_COUNT);

   assign block_count_in = csr_wr ? pwdata[bba_pkg::COUNT_W-1:0] : block_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= bba_pkg::BLOCK_COUNT_RESET;
      end else begin
         block_count_ff <= block_count_in;
      end
   end

   assign prdata = (paddr[2] == bba_pkg::REG_BLOCK_COUNT)
                 ? {{(bba_pkg::CSR_DATA_W - bba_pkg::COUNT_W){1'b0}}, block_count_ff}
                 : '0;

   // sequencing
   bba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .rsp_ready   (rsp_ready),
      .stat        (dp_stat),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .cmd         (dp_cmd)
   );

   // map, scanner and result register
   bba_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .block_count (block_count_ff),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* sv/bba_checker.sv */
// Port-level checker for the block bitmap allocator, bound to the top level.
`default_nettype none
`include "block_bitmap_allocator_core_defines.svh"

module bba_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire bba_pkg::rsp_type  rsp_payload
);

   // one request in work: ready drops right after an acceptance
   `BBA_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")

   // a pending response is held until taken
   `BBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response dropped")

   // full store reports block zero, bit clear
   `BBA_ASSERT_NOW(a_full_fields, clock, reset, rsp_valid && (rsp_payload.status == bba_pkg::STATUS_FULL), (rsp_payload.result_block == 8'd0) && !rsp_payload.was_used, "bad full response")

   // out-of-range never reports a used bit
   `BBA_ASSERT_NOW(a_range_fields, clock, reset, rsp_valid && (rsp_payload.status == bba_pkg::STATUS_RANGE), !rsp_payload.was_used, "bad range response")

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (.*);

`default_nettype wire
